>>> hw/rtl/sha256_pkg.sv
// Shared types, round constants and hash functions for the SHA-256 block.
// No dependencies; imported by sha256_ctrl, sha256_dp, sha256_hash and the testbench.
`default_nettype none

package sha256_pkg;

  // Source of the byte shifted into the message window
  typedef enum logic [1:0] {
    SRC_DATA  = 2'd0,
    SRC_PAD80 = 2'd1,
    SRC_ZERO  = 2'd2,
    SRC_LEN   = 2'd3
  } byte_src_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       byte_shift;   // shift one byte into the window
    byte_src_e  byte_src;
    logic [2:0] len_idx;      // byte of the bit length, 0 = most significant
    logic       count_inc;    // count one message byte
    logic       count_clr;
    logic       vars_load;    // working variables take the chaining value
    logic       round_en;     // run one compression round
    logic [5:0] round_idx;
    logic       chain_add;    // fold working variables into the chain
    logic       chain_init;   // back to the initial hash values
    logic [2:0] word_idx;     // digest word on the result port
  } sha256_cmd_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] sha256_iv(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sha256_k(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sha256_ctrl.sv
// Controller FSM: byte intake, padding sequence, round count, digest output.
// Depends on sha256_pkg; drives sha256_dp through sha256_cmd_t.
`default_nettype none

module sha256_ctrl
  import sha256_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire logic  has_byte_i,
  input  wire logic  last_i,
  output logic       busy_o,
  output logic       strobe_o,
  output logic       last_word_o,
  output sha256_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad80 = 3'd1;
  localparam logic [2:0] StPadZ  = 3'd2;
  localparam logic [2:0] StLen   = 3'd3;
  localparam logic [2:0] StComp  = 3'd4;
  localparam logic [2:0] StUpd   = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  localparam logic [5:0] FillFull = 6'd63;
  localparam logic [5:0] FillLen  = 6'd56;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;    // state to resume after a compression
  logic [5:0] fill_q, fill_d;  // bytes held in the window
  logic [5:0] cnt_q, cnt_d;    // round or digest word counter

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.byte_src  = SRC_DATA;
    cmd_o.len_idx   = fill_q[2:0];
    cmd_o.round_idx = cnt_q;
    cmd_o.word_idx  = cnt_q[2:0];
    strobe_o    = 1'b0;
    last_word_o = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          if (has_byte_i) begin
            cmd_o.byte_shift = 1'b1;
            cmd_o.count_inc  = 1'b1;
            fill_d = fill_q + 6'd1;
            if (fill_q == FillFull) begin
              cmd_o.vars_load = 1'b1;
              state_d = StComp;
              ret_d   = last_i ? StPad80 : StIdle;
            end else if (last_i) begin
              state_d = StPad80;
            end
          end else if (last_i) begin
            state_d = StPad80;
          end
        end
      end
      StPad80: begin
        cmd_o.byte_shift = 1'b1;
        cmd_o.byte_src   = SRC_PAD80;
        fill_d = fill_q + 6'd1;
        state_d = StPadZ;
        if (fill_q == FillFull) begin
          cmd_o.vars_load = 1'b1;
          state_d = StComp;
          ret_d   = StPadZ;
        end
      end
      StPadZ: begin
        if (fill_q == FillLen) begin
          state_d = StLen;
        end else begin
          cmd_o.byte_shift = 1'b1;
          cmd_o.byte_src   = SRC_ZERO;
          fill_d = fill_q + 6'd1;
          if (fill_q == FillFull) begin
            cmd_o.vars_load = 1'b1;
            state_d = StComp;
            ret_d   = StPadZ;
          end
        end
      end
      StLen: begin
        cmd_o.byte_shift = 1'b1;
        cmd_o.byte_src   = SRC_LEN;
        fill_d = fill_q + 6'd1;
        if (fill_q == FillFull) begin
          cmd_o.vars_load = 1'b1;
          state_d = StComp;
          ret_d   = StOut;
        end
      end
      StComp: begin
        cmd_o.round_en = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.chain_add = 1'b1;
        cnt_d   = '0;
        state_d = ret_q;
      end
      StOut: begin
        strobe_o = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[2:0] == 3'd7) begin
          last_word_o      = 1'b1;
          cmd_o.chain_init = 1'b1;
          cmd_o.count_clr  = 1'b1;
          cnt_d   = '0;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != StIdle);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      fill_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sha256_dp.sv
// Datapath: message window / schedule shift line, round unit, chaining value,
// byte counter. Depends on sha256_pkg; commanded by sha256_ctrl.
`default_nettype none

module sha256_dp
  import sha256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire sha256_cmd_t cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output logic      [31:0] digest_word_o
);

  logic [511:0] win_q, win_d;     // 16 words, word 0 in the top bits
  logic [31:0]  vars_q [8];       // a..h
  logic [31:0]  vars_d [8];
  logic [31:0]  chain_q [8];
  logic [60:0]  count_q;
  logic [63:0]  bit_len;
  logic [7:0]   byte_in;
  logic [31:0]  w0, w1, w9, w14, w_next;
  logic [31:0]  t1, t2;

  assign bit_len = {count_q, 3'b000};

  // Byte entering the window
  always_comb begin
    case (cmd_i.byte_src)
      SRC_DATA:  byte_in = data_byte_i;
      SRC_PAD80: byte_in = PadByte;
      SRC_ZERO:  byte_in = 8'h00;
      default:   byte_in = bit_len[63 - 8 * cmd_i.len_idx -: 8];
    endcase
  end

  // Schedule taps at fixed window positions
  assign w0  = win_q[511:480];
  assign w1  = win_q[479:448];
  assign w9  = win_q[223:192];
  assign w14 = win_q[63:32];
  assign w_next = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  always_comb begin
    win_d = win_q;
    if (cmd_i.byte_shift) begin
      win_d = {win_q[503:0], byte_in};
    end else if (cmd_i.round_en) begin
      win_d = {win_q[479:0], w_next};
    end
  end

  // One compression round
  assign t1 = vars_q[7] + big_sigma1(vars_q[4])
            + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
            + sha256_k(cmd_i.round_idx) + w0;
  assign t2 = big_sigma0(vars_q[0])
            + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));

  always_comb begin
    vars_d = vars_q;
    if (cmd_i.vars_load) begin
      vars_d = chain_q;
    end else if (cmd_i.round_en) begin
      vars_d[7] = vars_q[6];
      vars_d[6] = vars_q[5];
      vars_d[5] = vars_q[4];
      vars_d[4] = vars_q[3] + t1;
      vars_d[3] = vars_q[2];
      vars_d[2] = vars_q[1];
      vars_d[1] = vars_q[0];
      vars_d[0] = t1 + t2;
    end
  end

  // Window and working variables carry no reset
  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    vars_q <= vars_d;
  end

  // Chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sha256_iv(3'(i));
      end
    end else if (cmd_i.chain_init) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sha256_iv(3'(i));
      end
    end else if (cmd_i.chain_add) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_q[i] + vars_q[i];
      end
    end
  end

  // Message byte counter, wraps modulo 2^61
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.count_clr) begin
      count_q <= '0;
    end else if (cmd_i.count_inc) begin
      count_q <= count_q + 61'd1;
    end
  end

  assign digest_word_o = chain_q[cmd_i.word_idx];

endmodule

`default_nettype wire

>>> hw/rtl/sha256_hash.sv
// SHA-256 over a byte stream. Bytes are taken while idle; the byte that
// fills a 64-byte block holds busy for 64 rounds, one per cycle in the round
// unit, plus the chain update. On last: padding one byte a cycle to the block
// end, paused by each of one or two compressions, then eight digest words on
// consecutive cycles; the receiver cannot stall. Reset loads the initial hash
// values and clears counts.
`default_nettype none

module sha256_hash
  import sha256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        last_i,
  output logic             strobe_o,
  output logic      [31:0] digest_word_o,
  output logic      [2:0]  word_index_o,
  output logic             last_word_o
);

  sha256_cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .busy_o      (busy),
    .strobe_o    (strobe_o),
    .last_word_o (last_word_o),
    .cmd_o       (cmd)
  );

  sha256_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .digest_word_o (digest_word_o)
  );

  assign word_index_o = cmd.word_idx;

  // A digest word only appears while the block is busy
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy) else $error("digest transfer while idle");

  // Last word marker only on word seven of a transfer
  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_word_o |-> (strobe_o && word_index_o == 3'd7))
    else $error("last_word outside word seven");

  // Digest words come back to back in index order
  a_word_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_word_o) |=>
      (strobe_o && word_index_o == ($past(word_index_o) + 3'd1)))
    else $error("digest word sequence broken");

  // Closing a message always starts finalization
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> busy)
    else $error("last accepted without finalization");

endmodule

`default_nettype wire

>>> bench/sha256_hash_tb.sv
// Self-checking testbench for sha256_hash: byte-stream messages in, digest words out.
// Holds its own SHA-256 model and predicts every digest word.
// Depends only on sha256_pkg and the sha256_hash RTL.
`default_nettype none

module sha256_hash_tb;
  import sha256_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 20;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int LEN_FIELD_POS  = 56;
  localparam int BLOCK_LEN      = 64;

  localparam logic [0:7][31:0] HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Message lengths that land on the padding edges
  localparam logic [0:7][7:0] PAD_EDGE_LENS = {
    8'd55, 8'd56, 8'd57, 8'd63, 8'd64, 8'd65, 8'd119, 8'd120
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  word_idx;
    logic        is_last;
  } hash_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  data_byte_i = 8'h00;
  logic        has_byte_i = 1'b0;
  logic        last_i = 1'b0;
  logic        strobe_o;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // Model state
  logic [31:0] chain_h [8];
  logic [7:0]  blk_buf [64];
  int          blk_fill;
  logic [60:0] msg_bytes;
  hash_word_t  digest_q [$];

  int idle_pct;
  int items_sent;
  int msgs_closed;
  int words_checked;
  int err_cnt;
  int stall_cycles;
  hash_word_t due_word;

  sha256_hash dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .data_byte_i  (data_byte_i),
    .has_byte_i   (has_byte_i),
    .last_i       (last_i),
    .strobe_o     (strobe_o),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] rot_r(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = HASH_IV[i];
    blk_fill  = 0;
    msg_bytes = '0;
  endfunction

  // 64 rounds over blk_buf, folded into chain_h
  function automatic void hash_block();
    logic [31:0] w [64];
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rot_r(w[t-15], 7) ^ rot_r(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rot_r(w[t-2], 17) ^ rot_r(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {va, vb, vc, vd} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3]};
    {ve, vf, vg, vh} = {chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = vh + (rot_r(ve, 6) ^ rot_r(ve, 11) ^ rot_r(ve, 25))
              + ((ve & vf) ^ (~ve & vg)) + ROUND_K[t] + w[t];
      t2 = (rot_r(va, 2) ^ rot_r(va, 13) ^ rot_r(va, 22))
         + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + t1;
      vd = vc; vc = vb; vb = va; va = t1 + t2;
    end
    chain_h[0] += va; chain_h[1] += vb; chain_h[2] += vc; chain_h[3] += vd;
    chain_h[4] += ve; chain_h[5] += vf; chain_h[6] += vg; chain_h[7] += vh;
  endfunction

  // Absorb one accepted transfer; on last, pad and queue the eight digest words
  function automatic void absorb_transfer(input logic [7:0] d, input logic hb,
                                          input logic lst);
    logic [63:0] bit_len;
    int pos;
    hash_word_t hw;
    if (hb) begin
      blk_buf[blk_fill] = d;
      blk_fill++;
      msg_bytes++;
      if (blk_fill == BLOCK_LEN) begin
        hash_block();
        blk_fill = 0;
      end
    end
    if (lst) begin
      blk_buf[blk_fill] = PAD_BYTE;
      pos = blk_fill + 1;
      // no room for the length: extra block
      if (pos > LEN_FIELD_POS) begin
        while (pos < BLOCK_LEN) begin
          blk_buf[pos] = 8'h00;
          pos++;
        end
        hash_block();
        pos = 0;
      end
      while (pos < LEN_FIELD_POS) begin
        blk_buf[pos] = 8'h00;
        pos++;
      end
      bit_len = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) blk_buf[LEN_FIELD_POS + i] = bit_len[63 - 8*i -: 8];
      hash_block();
      for (int i = 0; i < 8; i++) begin
        hw = {chain_h[i], 3'(i), 1'(i == 7)};
        digest_q = {digest_q, hw};
      end
      msgs_closed++;
      restart_hash();
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("digest word %h with nothing pending", digest_word_o));
      end else begin
        due_word = digest_q.pop_front();
        words_checked++;
        if (digest_word_o !== due_word.word)
          report_mismatch($sformatf("word %0d: got %h, want %h",
                                    due_word.word_idx, digest_word_o, due_word.word));
        if (word_index_o !== due_word.word_idx)
          report_mismatch($sformatf("word index: got %0d, want %0d",
                                    word_index_o, due_word.word_idx));
        if (last_word_o !== due_word.is_last)
          report_mismatch($sformatf("last_word on word %0d: got %b, want %b",
                                    due_word.word_idx, last_word_o, due_word.is_last));
      end
    end
  end

  // Watchdog: cycles without any transfer on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Called at a falling edge; returns at a falling edge with start still high
  task automatic send_item(input logic [7:0] d, input logic hb, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start       <= 1'b1;
    data_byte_i <= d;
    has_byte_i  <= hb;
    last_i      <= lst;
    do @(posedge clk_i); while (busy);
    absorb_transfer(d, hb, lst);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold off until every pending digest word has come out
  task automatic wait_for_digests();
    start <= 1'b0;
    @(negedge clk_i);
    while (digest_q.size() != 0) @(negedge clk_i);
  endtask

  // One message of len bytes with random content and the odd ignored transfer
  task automatic send_message(input int len);
    logic split_end;
    split_end = (len == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !split_end && (i == len - 1));
    end
    if (split_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(12);
    if (r < 85) return PAD_EDGE_LENS[$urandom_range(7)];
    return $urandom_range(130);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_empty_message();
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Data on a transfer without has_byte must not enter the message
  task automatic test_ignored_transfer();
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
  endtask

  // Byte and last in one transfer
  task automatic test_byte_with_last();
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
  endtask

  task automatic test_extreme_bytes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
  endtask

  // Lengths where the length field just fits, just misses, and a full block
  task automatic test_pad_boundaries();
    send_message(55);
    send_message(56);
    send_message(64);
  endtask

  task automatic test_random_traffic(input int pct, input int quota);
    int base;
    base     = items_sent;
    idle_pct = pct;
    while (items_sent - base < quota) send_message(pick_length());
  endtask

  initial begin
    restart_hash();
    idle_pct      = 0;
    items_sent    = 0;
    msgs_closed   = 0;
    words_checked = 0;
    err_cnt       = 0;
    stall_cycles  = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 31;
    test_empty_message();
    test_ignored_transfer();
    test_byte_with_last();
    test_extreme_bytes();
    wait_for_digests();

    idle_pct = 0;
    test_pad_boundaries();
    wait_for_digests();

    test_random_traffic(0, 45);
    wait_for_digests();
    test_random_traffic(69, 45);
    wait_for_digests();
    test_random_traffic(31, 45);

    wait_for_digests();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run: %0d input transfers, %0d messages (padding edges, empty, split last)",
             items_sent, msgs_closed);
    $display("     %0d digest words checked at sender idle 0/69/31 pct, %0d mismatches",
             words_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sha256_hash.f
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_dp.sv
hw/rtl/sha256_hash.sv
bench/sha256_hash_tb.sv
